// ----- rtl/ecsg_pkg.sv -----
// ----------------------------------------------------------------------------
// ecsg_pkg
// Shared types and codes for the encoder counter with storm guard.
// ----------------------------------------------------------------------------
package ecsg_pkg;

  localparam logic [1:0] REQ_EDGE  = 2'd0;
  localparam logic [1:0] REQ_POLL  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_RESET = 2'd3;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_MS    = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGES_PER_MS = 8'd1;

  localparam logic [CFG_DATA_W-1:0] WINDOW_MS_RST    = 16'd100;
  localparam logic [CFG_DATA_W-1:0] EDGES_PER_MS_RST = 16'd20;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        level_a;
    logic        level_b;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tick_value;
    logic signed [31:0] total_tick_value;
    logic [31:0]        edge_total;
    logic               storm_detected;
    logic               is_detached;
  } out_item_t;

endpackage

// ----- rtl/ecsg_core.sv -----
// ----------------------------------------------------------------------------
// ecsg_core
// Counter state and storm check; updates state and forms one result per item.
// ----------------------------------------------------------------------------
module ecsg_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   advance,
  input  ecsg_pkg::in_item_t                     item,
  input  logic [ecsg_pkg::CFG_DATA_W-1:0]        window_ms,
  input  logic [ecsg_pkg::CFG_DATA_W-1:0]        edges_per_ms,
  output ecsg_pkg::out_item_t                    result
);

  logic [COUNT_WIDTH-1:0] tick_accum_r, tick_accum_nxt;
  logic [COUNT_WIDTH-1:0] total_steps_r, total_steps_nxt;
  logic [COUNT_WIDTH-1:0] edge_count_r, edge_count_nxt;
  logic [COUNT_WIDTH-1:0] edge_mark_r, edge_mark_nxt;
  logic [31:0]            window_start_r, window_start_nxt;
  logic                   detached_r, detached_nxt;

  logic [COUNT_WIDTH-1:0] step;
  logic [COUNT_WIDTH-1:0] seen;
  logic [31:0]            elapsed;
  logic [47:0]            budget;
  logic                   judged;
  logic                   over_budget;
  logic                   storm;
  logic [COUNT_WIDTH-1:0] read_val;
  logic signed [63:0]     read_ext;
  logic signed [63:0]     total_ext;
  logic [63:0]            edge_ext;

  assign step        = (item.level_a == item.level_b) ? COUNT_WIDTH'(1) : '1;
  assign elapsed     = item.now_ms - window_start_r;
  assign judged      = elapsed >= {16'd0, window_ms};
  assign budget      = 48'(edges_per_ms) * 48'(elapsed);
  assign seen        = edge_count_r - edge_mark_r;
  assign over_budget = 64'(seen) > 64'(budget);

  always_comb begin
    tick_accum_nxt   = tick_accum_r;
    total_steps_nxt  = total_steps_r;
    edge_count_nxt   = edge_count_r;
    edge_mark_nxt    = edge_mark_r;
    window_start_nxt = window_start_r;
    detached_nxt     = detached_r;
    storm            = 1'b0;
    read_val         = '0;
    case (item.req_type)
      ecsg_pkg::REQ_EDGE: begin
        if (!detached_r) begin
          tick_accum_nxt  = tick_accum_r + step;
          total_steps_nxt = total_steps_r + step;
          edge_count_nxt  = edge_count_r + COUNT_WIDTH'(1);
        end
      end
      ecsg_pkg::REQ_POLL: begin
        if (!detached_r) begin
          if (window_start_r == 32'd0) begin
            window_start_nxt = item.now_ms;
            edge_mark_nxt    = edge_count_r;
          end else if (judged) begin
            window_start_nxt = item.now_ms;
            edge_mark_nxt    = edge_count_r;
            if (over_budget) begin
              detached_nxt = 1'b1;
              storm        = 1'b1;
            end
          end
        end
      end
      ecsg_pkg::REQ_READ: begin
        read_val       = tick_accum_r;
        tick_accum_nxt = '0;
      end
      ecsg_pkg::REQ_RESET: begin
        total_steps_nxt = '0;
        if (detached_r) begin
          detached_nxt     = 1'b0;
          window_start_nxt = 32'd0;
        end
      end
      default: begin
        tick_accum_nxt = tick_accum_r;
      end
    endcase
  end

  assign read_ext  = 64'($signed(read_val));
  assign total_ext = 64'($signed(total_steps_nxt));
  assign edge_ext  = 64'(edge_count_nxt);

  assign result.tick_value       = read_ext[31:0];
  assign result.total_tick_value = total_ext[31:0];
  assign result.edge_total       = edge_ext[31:0];
  assign result.storm_detected   = storm;
  assign result.is_detached      = detached_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_accum_r   <= '0;
      total_steps_r  <= '0;
      edge_count_r   <= '0;
      edge_mark_r    <= '0;
      window_start_r <= 32'd0;
      detached_r     <= 1'b0;
    end else if (advance) begin
      tick_accum_r   <= tick_accum_nxt;
      total_steps_r  <= total_steps_nxt;
      edge_count_r   <= edge_count_nxt;
      edge_mark_r    <= edge_mark_nxt;
      window_start_r <= window_start_nxt;
      detached_r     <= detached_nxt;
    end
  end

endmodule

// ----- rtl/encoder_counter_with_storm_guard.sv -----
// An input transfer loads the input register, and its result then loads the
// result register. Throughput: one item per cycle unless the output stalls;
// the input register and the result register each hold one item, and the
// counter state updates as an item leaves the input register. Synchronous
// active-low reset clears all counters, unarms the window, clears detach, and loads window_ms = 100, edges_per_ms = 20.
// ----------------------------------------------------------------------------
// encoder_counter_with_storm_guard
// Quadrature x2 step counter with edge-storm detach guard, top level.
// ----------------------------------------------------------------------------
module encoder_counter_with_storm_guard #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ecsg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ecsg_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ecsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ecsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                                 in_valid_r;
  ecsg_pkg::in_item_t                   in_item_r;
  logic                                 out_valid_r;
  ecsg_pkg::out_item_t                  out_item_r;
  ecsg_pkg::out_item_t                  result;
  logic [ecsg_pkg::CFG_DATA_W-1:0]      window_ms_r;
  logic [ecsg_pkg::CFG_DATA_W-1:0]      edges_per_ms_r;
  logic                                 advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;
  assign cfg_ready = 1'b1;

  ecsg_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .item         (in_item_r),
    .window_ms    (window_ms_r),
    .edges_per_ms (edges_per_ms_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r    <= ecsg_pkg::WINDOW_MS_RST;
      edges_per_ms_r <= ecsg_pkg::EDGES_PER_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ecsg_pkg::CFG_WINDOW_MS) begin
        window_ms_r <= cfg_data;
      end else if (cfg_index == ecsg_pkg::CFG_EDGES_PER_MS) begin
        edges_per_ms_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

`ifndef SYNTHESIS
  a_storm_implies_detached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.storm_detected |-> out_item_r.is_detached)
    else $error("storm reported without detach");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side drains");
`endif

endmodule
